### rtl/lps_pkg.sv
// Shared types and the point compare function for the lexicographic point sorter.
// No dependencies; every module of the sorter imports this package.
package lps_pkg;

    localparam int NUM_COORDS = 4;
    localparam int DIMS_W     = 3;

    typedef logic [31:0] t_coord;
    typedef t_coord [NUM_COORDS-1:0] t_coords;

    typedef struct packed {
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [31:0] coord_d;
        logic               final_point;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic signed [31:0] out_d;
        logic               run_end;
        logic               overflowed;
    } t_result;

    typedef struct packed {
        logic              insert;
        logic              drain;
        logic [DIMS_W-1:0] dims;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    localparam logic [0:0] REG_DIMS = 1'b0;

    // True when a is strictly below b in the first dims coordinates (signed order).
    function automatic logic point_less(input t_coords a, input t_coords b,
                                        input logic [DIMS_W-1:0] dims);
        logic res;
        res = 1'b0;
        // Walk from the last coordinate down so the first difference wins.
        for (int k = NUM_COORDS - 1; k >= 0; k--) begin
            if ((DIMS_W'(k) < dims) && (a[k] != b[k])) begin
                res = ($signed(a[k]) < $signed(b[k]));
            end
        end
        return res;
    endfunction

endpackage

### rtl/lps_cell.sv
// One slot of the insertion chain: holds a point and its valid bit.
// Depends on lps_pkg for the point type, control struct and compare function.
module lps_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lps_pkg::t_cell_ctl i_ctl,
    input  lps_pkg::t_coords  i_new,
    input  lps_pkg::t_coords  i_prev_data,
    input  logic              i_prev_valid,
    input  logic              i_prev_take,
    input  lps_pkg::t_coords  i_next_data,
    input  logic              i_next_valid,
    output lps_pkg::t_coords  o_data,
    output logic              o_valid,
    output logic              o_take
);
    import lps_pkg::*;

    t_coords r_data;
    logic    r_valid;

    // An empty slot sorts after any point; a held point moves up when the new one is smaller.
    assign o_take  = !r_valid || point_less(i_new, r_data, i_ctl.dims);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_data <= i_next_data;
        end else if (i_ctl.insert && o_take) begin
            r_data <= i_prev_take ? i_prev_data : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.drain) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.insert) begin
            r_valid <= r_valid | i_prev_valid;
        end
    end

endmodule

### rtl/lexicographic_point_sorter_unit.sv
// Top level of the lexicographic point sorter: APB register, control and cell chain.
// Depends on lps_pkg and lps_cell.
//
// Usage:
//   Points enter on i_point, one per transfer, taken at a clock edge with start high
//   and busy low. Each point drops into its sorted place in the chain of cells in
//   the same cycle, so a set loads at one point per cycle.
//   A point with final_point set is stored like the others, then busy rises and the
//   chain shifts toward cell 0 once a cycle. Sorted points appear on o_result with
//   o_strobe high for one cycle each, the first after the state register has raised
//   busy and the output register has taken the head cell. run_end marks the last one,
//   and overflowed on it reports points dropped because all MAX_POINTS cells were full.
//   The receiver cannot stall: every strobed result is taken.
//   dims_in_use sits at APB address 0 (reset 2) and sets how many leading coordinates
//   are compared; values above MAX_DIMS compare MAX_DIMS. Write it only while idle.
//   Reset empties the chain, clears the overflow flag and returns to idle.
module lexicographic_point_sorter_unit #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lps_pkg::t_point_in i_point,
    output logic               o_strobe,
    output lps_pkg::t_result   o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lps_pkg::*;

    t_state            r_state, n_state;
    logic [DIMS_W-1:0] r_dims;
    logic              r_ovf;
    logic              r_strobe;
    t_result           r_result;

    t_coords           w_data  [MAX_POINTS];
    logic [MAX_POINTS-1:0] w_valid;
    logic [MAX_POINTS-1:0] w_take;
    t_coords           w_new;
    t_cell_ctl         w_ctl;
    logic              w_accept;
    logic              w_full;
    logic              w_last_out;

    assign pready   = 1'b1;
    assign busy     = (r_state == ST_DRAIN);
    assign w_accept = start && !busy;
    assign w_full   = w_valid[MAX_POINTS-1];
    assign w_last_out = !w_valid[1];

    assign w_new[0] = i_point.coord_a;
    assign w_new[1] = i_point.coord_b;
    assign w_new[2] = i_point.coord_c;
    assign w_new[3] = i_point.coord_d;

    always_comb begin
        w_ctl.insert = w_accept && !w_full;
        w_ctl.drain  = busy;
        w_ctl.dims   = (r_dims > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : r_dims;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(2);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIMS)) begin
            r_dims <= pwdata[DIMS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DIMS) ? {{(32-DIMS_W){1'b0}}, r_dims} : 32'd0;

    // Cell chain
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        t_coords w_prev_data;
        logic    w_prev_valid;
        logic    w_prev_take;
        t_coords w_next_data;
        logic    w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_data  = w_new;
            assign w_prev_valid = 1'b1;
            assign w_prev_take  = 1'b0;
        end else begin : g_body
            assign w_prev_data  = w_data[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_take  = w_take[g-1];
        end

        if (g == MAX_POINTS - 1) begin : g_tail
            assign w_next_data  = w_data[g];
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_data  = w_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        lps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_prev_data (w_prev_data),
            .i_prev_valid(w_prev_valid),
            .i_prev_take (w_prev_take),
            .i_next_data (w_next_data),
            .i_next_valid(w_next_valid),
            .o_data      (w_data[g]),
            .o_valid     (w_valid[g]),
            .o_take      (w_take[g])
        );
    end

    // Control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_point.final_point) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_last_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= busy;
            if (busy && w_last_out) begin
                r_ovf <= 1'b0;
            end else if (w_accept && w_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Output register: take the head cell while the chain advances
    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_result.out_a      <= w_data[0][0];
            r_result.out_b      <= w_data[0][1];
            r_result.out_c      <= w_data[0][2];
            r_result.out_d      <= w_data[0][3];
            r_result.run_end    <= w_last_out;
            r_result.overflowed <= w_last_out && r_ovf;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Assertions
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MAX_POINTS'(1))) == '0)
        else $error("cell valid bits are not a contiguous prefix");

    a_strobe_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a drain cycle");

    a_run_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.run_end) |=> !o_strobe)
        else $error("result follows the end of a run");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_valid[0])
        else $error("draining an empty chain");

endmodule
